// ===== src/tpt_pkg.sv =====
// ----------------------------------------------------------------------------
// tpt_pkg
// Shared types and fixed field widths for the TLB / page table translator.
// ----------------------------------------------------------------------------
package tpt_pkg;

  // Fixed widths of the transaction fields
  localparam int AddrW  = 16;
  localparam int ByteW  = 8;
  localparam int CountW = 32;

  // Update command from the control logic to the TLB
  typedef struct packed {
    logic fill;   // write a new translation
    logic flush;  // drop every entry first, restart the fill pointer
  } tlb_cmd_t;

endpackage

// ===== src/tlb_page_table_translator.sv =====
// ----------------------------------------------------------------------------
// tlb_page_table_translator
// Flow: an accepted address is registered with its page map and owner reads,
// then looked up and its result registered; a stalled result holds the
// lookup until it is taken. No new address is accepted until the lookup
// completes, nor, after a fault that evicts another page's mapping, until
// that mapping is cleared. Reset: TLB cleared at once; then a clearing pass
// of max(2**PAGE_WIDTH, FRAME_COUNT) entries (256 by default), input stalled.
// ----------------------------------------------------------------------------
module tlb_page_table_translator #(
  parameter int OFFSET_WIDTH = 8,
  parameter int PAGE_WIDTH   = 8,
  parameter int FRAME_COUNT  = 256,
  parameter int TLB_ENTRIES  = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // address channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [tpt_pkg::AddrW-1:0]   logical_address_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [tpt_pkg::AddrW-1:0]   physical_address_o,
  output logic                        tlb_hit_o,
  output logic                        fault_taken_o,
  output logic [tpt_pkg::ByteW-1:0]   fault_frame_o,
  output logic                        evicted_valid_o,
  output logic [tpt_pkg::ByteW-1:0]   evicted_page_o,
  output logic [tpt_pkg::CountW-1:0]  access_count_o,
  output logic [tpt_pkg::CountW-1:0]  tlb_miss_count_o,
  output logic [tpt_pkg::CountW-1:0]  fault_count_o
);
  import tpt_pkg::*;

  localparam int PageSlots = 1 << PAGE_WIDTH;
  localparam int FrameW    = $clog2(FRAME_COUNT);
  localparam int ClrDepth  = (PageSlots > FRAME_COUNT) ? PageSlots : FRAME_COUNT;
  localparam int ClrW      = $clog2(ClrDepth);
  localparam int InW       = AddrW + OFFSET_WIDTH + PAGE_WIDTH;
  localparam int PaW       = AddrW + FrameW + OFFSET_WIDTH;
  localparam int FfW       = ByteW + FrameW;
  localparam int EvW       = ByteW + PAGE_WIDTH;

  localparam logic [1:0] S_CLEAR  = 2'd0;
  localparam logic [1:0] S_IDLE   = 2'd1;
  localparam logic [1:0] S_LOOKUP = 2'd2;
  localparam logic [1:0] S_EVICT  = 2'd3;

  logic [1:0]              state_q, state_d;
  logic [ClrW-1:0]         clr_q;
  logic                    clr_last;
  logic                    accept;
  logic                    go;

  logic [InW-1:0]          in_wide;
  logic [PAGE_WIDTH-1:0]   page_in;
  logic [PAGE_WIDTH-1:0]   page_q;
  logic [OFFSET_WIDTH-1:0] offset_q;
  logic [FrameW-1:0]       nff_q;

  logic                    map_we;
  logic [PAGE_WIDTH-1:0]   map_waddr;
  logic [FrameW:0]         map_wdata;
  logic [FrameW:0]         map_rdata;
  logic                    own_we;
  logic [FrameW-1:0]       own_waddr;
  logic [PAGE_WIDTH:0]     own_wdata;
  logic [PAGE_WIDTH:0]     own_rdata;

  logic                    tlb_hit;
  logic [FrameW-1:0]       tlb_frame;
  tlb_cmd_t                tlb_cmd;

  logic                    miss;
  logic                    fault;
  logic                    evict;
  logic [FrameW-1:0]       frame_sel;
  logic [PaW-1:0]          pa_wide;
  logic [FfW-1:0]          ff_wide;
  logic [EvW-1:0]          ev_wide;

  logic                    out_valid_q;
  logic [AddrW-1:0]        pa_q;
  logic                    hit_q;
  logic                    fault_q;
  logic [ByteW-1:0]        ff_q;
  logic                    ev_valid_q;
  logic [ByteW-1:0]        ev_page_q;
  logic [CountW-1:0]       acc_cnt_q;
  logic [CountW-1:0]       miss_cnt_q;
  logic [CountW-1:0]       fault_cnt_q;

  // Handshake
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign go         = (state_q == S_LOOKUP) && (!out_valid_q || !out_stall_i);
  assign clr_last   = (clr_q == ClrW'(ClrDepth - 1));

  // Split the address; bits above the page number drop out
  assign in_wide = InW'(logical_address_i);
  assign page_in = in_wide[OFFSET_WIDTH +: PAGE_WIDTH];

  // Decode the lookup cycle
  assign miss      = !tlb_hit;
  assign fault     = miss && !map_rdata[FrameW];
  assign evict     = fault && own_rdata[PAGE_WIDTH];
  assign frame_sel = tlb_hit ? tlb_frame : (fault ? nff_q : map_rdata[FrameW-1:0]);
  assign pa_wide   = PaW'({frame_sel, offset_q});
  assign ff_wide   = FfW'(nff_q);
  assign ev_wide   = EvW'(own_rdata[PAGE_WIDTH-1:0]);

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_d = S_LOOKUP;
      end
      S_LOOKUP: begin
        if (go) state_d = evict ? S_EVICT : S_IDLE;
      end
      S_EVICT: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + ClrW'(1);
      end
    end
  end

  // Page map write port: clear, map on fault, unmap the evicted owner
  always_comb begin
    map_we    = 1'b0;
    map_waddr = page_q;
    map_wdata = '0;
    case (state_q)
      S_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_q[PAGE_WIDTH-1:0];
      end
      S_LOOKUP: begin
        map_we    = go && fault;
        map_wdata = {1'b1, nff_q};
      end
      S_EVICT: begin
        map_we    = 1'b1;
        map_waddr = own_rdata[PAGE_WIDTH-1:0];
      end
      default: begin
        map_we = 1'b0;
      end
    endcase
  end

  // Frame owner write port: clear, claim the frame on fault
  always_comb begin
    own_we    = 1'b0;
    own_waddr = nff_q;
    own_wdata = {1'b1, page_q};
    if (state_q == S_CLEAR) begin
      own_we    = ({1'b0, clr_q} < (ClrW + 1)'(FRAME_COUNT));
      own_waddr = clr_q[FrameW-1:0];
      own_wdata = '0;
    end else if (state_q == S_LOOKUP) begin
      own_we = go && fault;
    end
  end

  tpt_ram #(
    .DEPTH (PageSlots),
    .WIDTH (FrameW + 1)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .re_i    (accept),
    .raddr_i (page_in),
    .rdata_o (map_rdata)
  );

  tpt_ram #(
    .DEPTH (FRAME_COUNT),
    .WIDTH (PAGE_WIDTH + 1)
  ) u_owner_ram (
    .clk_i   (clk_i),
    .we_i    (own_we),
    .waddr_i (own_waddr),
    .wdata_i (own_wdata),
    .re_i    (accept),
    .raddr_i (nff_q),
    .rdata_o (own_rdata)
  );

  // Fill the TLB after every miss; flush it on a fault
  assign tlb_cmd.fill  = go && miss;
  assign tlb_cmd.flush = fault;

  tpt_tlb #(
    .ENTRIES     (TLB_ENTRIES),
    .PAGE_WIDTH  (PAGE_WIDTH),
    .FRAME_WIDTH (FrameW)
  ) u_tlb (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .lookup_page_i (page_q),
    .hit_o         (tlb_hit),
    .hit_frame_o   (tlb_frame),
    .cmd_i         (tlb_cmd),
    .fill_page_i   (page_q),
    .fill_frame_i  (frame_sel)
  );

  // Hold the address of the transaction in flight
  always_ff @(posedge clk_i) begin
    if (accept) begin
      page_q   <= page_in;
      offset_q <= in_wide[OFFSET_WIDTH-1:0];
    end
  end

  // Advance the FIFO frame pointer and the counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nff_q       <= '0;
      acc_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      fault_cnt_q <= '0;
    end else if (go) begin
      acc_cnt_q  <= acc_cnt_q + CountW'(1);
      miss_cnt_q <= miss_cnt_q + CountW'(miss);
      if (fault) begin
        fault_cnt_q <= fault_cnt_q + CountW'(1);
        nff_q       <= (nff_q == FrameW'(FRAME_COUNT - 1)) ? '0 : nff_q + FrameW'(1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (go) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      pa_q       <= pa_wide[AddrW-1:0];
      hit_q      <= tlb_hit;
      fault_q    <= fault;
      ff_q       <= fault ? ff_wide[ByteW-1:0] : '0;
      ev_valid_q <= evict;
      ev_page_q  <= evict ? ev_wide[ByteW-1:0] : '0;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign physical_address_o = pa_q;
  assign tlb_hit_o          = hit_q;
  assign fault_taken_o      = fault_q;
  assign fault_frame_o      = ff_q;
  assign evicted_valid_o    = ev_valid_q;
  assign evicted_page_o     = ev_page_q;
  assign access_count_o     = acc_cnt_q;
  assign tlb_miss_count_o   = miss_cnt_q;
  assign fault_count_o      = fault_cnt_q;

`ifndef SYNTHESIS
  // A fault never comes from a TLB hit
  a_hit_no_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(tlb_hit_o && fault_taken_o))
    else $error("TLB hit reported together with a page fault");

  // An eviction only happens as part of a fault
  a_evict_in_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && evicted_valid_o) |-> fault_taken_o)
    else $error("eviction reported without a page fault");

  // The unmapped owner is never the page just mapped
  a_evict_other_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVICT) |-> (map_waddr != page_q))
    else $error("eviction unmaps the page that was just mapped");

  // Every lookup that completes leaves a result behind
  a_go_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go |=> (out_valid_o && (access_count_o == $past(access_count_o) + CountW'(1))))
    else $error("completed lookup produced no result");
`endif

endmodule

// ===== src/tpt_ram.sv =====
// ----------------------------------------------------------------------------
// tpt_ram
// Single-clock memory: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module tpt_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 9
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data registered; it holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/tpt_tlb.sv =====
// ----------------------------------------------------------------------------
// tpt_tlb
// Fully associative TLB in flops: parallel tag match with lowest-slot
// priority, round-robin fill, whole-array flush.
// ----------------------------------------------------------------------------
module tpt_tlb #(
  parameter int ENTRIES     = 16,
  parameter int PAGE_WIDTH  = 8,
  parameter int FRAME_WIDTH = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [PAGE_WIDTH-1:0]  lookup_page_i,
  output logic                   hit_o,
  output logic [FRAME_WIDTH-1:0] hit_frame_o,
  input  tpt_pkg::tlb_cmd_t      cmd_i,
  input  logic [PAGE_WIDTH-1:0]  fill_page_i,
  input  logic [FRAME_WIDTH-1:0] fill_frame_i
);
  import tpt_pkg::*;

  localparam int SlotW = $clog2(ENTRIES);

  logic [PAGE_WIDTH-1:0]  tag_q   [ENTRIES];
  logic [FRAME_WIDTH-1:0] frame_q [ENTRIES];
  logic [ENTRIES-1:0]     valid_q;
  logic [ENTRIES-1:0]     valid_d;
  logic [SlotW-1:0]       ptr_q;
  logic [SlotW-1:0]       slot;

  // Match every entry; scan downward so the lowest slot wins
  always_comb begin
    hit_o       = 1'b0;
    hit_frame_o = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_q[i] && (tag_q[i] == lookup_page_i)) begin
        hit_o       = 1'b1;
        hit_frame_o = frame_q[i];
      end
    end
  end

  // A flush restarts filling at slot zero
  assign slot = cmd_i.flush ? '0 : ptr_q;

  // Drop every valid bit on a flush, then mark the filled slot
  always_comb begin
    valid_d       = cmd_i.flush ? '0 : valid_q;
    valid_d[slot] = 1'b1;
  end

  // Valid bits and fill pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      ptr_q   <= '0;
    end else if (cmd_i.fill) begin
      valid_q <= valid_d;
      ptr_q   <= (slot == SlotW'(ENTRIES - 1)) ? '0 : slot + SlotW'(1);
    end
  end

  // Tag and frame payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.fill) begin
      tag_q[slot]   <= fill_page_i;
      frame_q[slot] <= fill_frame_i;
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for tlb_page_table_translator. A scoreboard class keeps
// its own copy of the TLB, the page map and the FIFO frame owners and works
// out each translation as the address is accepted. Every result transaction
// is checked in order, field by field. Addresses come in random bursts mixed
// from a small hot page set, page scans and fully random values. The result
// side stalls on changing patterns, with one long hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OFF_W       = 8;
  localparam int PAGE_W      = 8;
  localparam int FRAME_SLOTS = 256;
  localparam int TLB_SLOTS   = 16;
  localparam int PAGE_SLOTS  = 1 << PAGE_W;

  localparam int RANDOM_ITEMS = 1900;
  localparam int HOLD_AT      = 500;
  localparam int PAUSE_AT     = 1200;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 8;
  localparam longint TIMEOUT_NS = 5_000_000;

  // One translation result as seen on the output ports
  typedef struct packed {
    logic [tpt_pkg::AddrW-1:0]  phys;
    logic                       hit;
    logic                       fault;
    logic [tpt_pkg::ByteW-1:0]  fault_frame;
    logic                       ev_valid;
    logic [tpt_pkg::ByteW-1:0]  ev_page;
    logic [tpt_pkg::CountW-1:0] accesses;
    logic [tpt_pkg::CountW-1:0] misses;
    logic [tpt_pkg::CountW-1:0] faults;
  } translation_t;

  // --------------------------------------------------------------------------
  // Scoreboard: translation predictor plus queue of outstanding results
  // --------------------------------------------------------------------------
  class translation_board;
    logic [PAGE_W-1:0]        tlb_tag   [TLB_SLOTS];
    logic [7:0]               tlb_frm   [TLB_SLOTS];
    bit                       tlb_vld   [TLB_SLOTS];
    logic [7:0]               page_frame[PAGE_SLOTS];
    bit                       page_mapped[PAGE_SLOTS];
    logic [PAGE_W-1:0]        owner_page[FRAME_SLOTS];
    bit                       owner_vld [FRAME_SLOTS];
    logic [7:0]               fifo_frame;
    logic [3:0]               fill_ptr;
    logic [31:0]              n_access;
    logic [31:0]              n_miss;
    logic [31:0]              n_fault;
    translation_t             outstanding_q[$];
    int                       errors;

    function new();
      flush_tlb();
      foreach (page_frame[i]) begin
        page_frame[i]  = '0;
        page_mapped[i] = 1'b0;
      end
      foreach (owner_vld[i]) begin
        owner_page[i] = '0;
        owner_vld[i]  = 1'b0;
      end
      fifo_frame = '0;
      n_access   = '0;
      n_miss     = '0;
      n_fault    = '0;
      errors     = 0;
    endfunction

    function void flush_tlb();
      foreach (tlb_vld[i]) begin
        tlb_tag[i] = '0;
        tlb_frm[i] = '0;
        tlb_vld[i] = 1'b0;
      end
      fill_ptr = '0;
    endfunction

    function int pending();
      return outstanding_q.size();
    endfunction

    // Translate an accepted address and queue the result it must produce
    function void note_address(logic [15:0] la);
      logic [PAGE_W-1:0] page;
      logic [7:0]        frame;
      logic [7:0]        victim;
      translation_t      want;
      page  = la[OFF_W +: PAGE_W];
      frame = '0;
      want  = '0;
      n_access++;
      // lowest valid match wins
      for (int i = 0; i < TLB_SLOTS; i++) begin
        if (tlb_vld[i] && tlb_tag[i] == page && !want.hit) begin
          frame    = tlb_frm[i];
          want.hit = 1'b1;
        end
      end
      if (!want.hit) begin
        n_miss++;
        if (!page_mapped[page]) begin
          // take the next frame in FIFO order, unmap its old owner
          want.fault       = 1'b1;
          want.fault_frame = fifo_frame;
          n_fault++;
          if (owner_vld[fifo_frame]) begin
            victim              = owner_page[fifo_frame];
            want.ev_valid       = 1'b1;
            want.ev_page        = victim;
            page_mapped[victim] = 1'b0;
          end
          owner_page[fifo_frame] = page;
          owner_vld[fifo_frame]  = 1'b1;
          page_frame[page]       = fifo_frame;
          page_mapped[page]      = 1'b1;
          fifo_frame             = fifo_frame + 8'd1;
          flush_tlb();
        end
        frame             = page_frame[page];
        tlb_tag[fill_ptr] = page;
        tlb_frm[fill_ptr] = frame;
        tlb_vld[fill_ptr] = 1'b1;
        fill_ptr          = fill_ptr + 4'd1;
      end
      want.phys     = {frame, la[OFF_W-1:0]};
      want.accesses = n_access;
      want.misses   = n_miss;
      want.faults   = n_fault;
      outstanding_q.push_back(want);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                 $time, name, want, got);
      end
    endfunction

    // Check one result transaction against the oldest outstanding one
    function void check_translation(translation_t got);
      translation_t want;
      if (outstanding_q.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result, expected none, actual physical_address 0x%0h",
                 $time, got.phys);
        return;
      end
      want = outstanding_q.pop_front();
      compare_field("physical_address", 32'(want.phys), 32'(got.phys));
      compare_field("tlb_hit", 32'(want.hit), 32'(got.hit));
      compare_field("fault_taken", 32'(want.fault), 32'(got.fault));
      compare_field("fault_frame", 32'(want.fault_frame), 32'(got.fault_frame));
      compare_field("evicted_valid", 32'(want.ev_valid), 32'(got.ev_valid));
      compare_field("evicted_page", 32'(want.ev_page), 32'(got.ev_page));
      compare_field("access_count", want.accesses, got.accesses);
      compare_field("tlb_miss_count", want.misses, got.misses);
      compare_field("fault_count", want.faults, got.faults);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and block under test
  // --------------------------------------------------------------------------
  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic [tpt_pkg::AddrW-1:0]  logical_address_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [tpt_pkg::AddrW-1:0]  physical_address_o;
  logic                       tlb_hit_o;
  logic                       fault_taken_o;
  logic [tpt_pkg::ByteW-1:0]  fault_frame_o;
  logic                       evicted_valid_o;
  logic [tpt_pkg::ByteW-1:0]  evicted_page_o;
  logic [tpt_pkg::CountW-1:0] access_count_o;
  logic [tpt_pkg::CountW-1:0] tlb_miss_count_o;
  logic [tpt_pkg::CountW-1:0] fault_count_o;

  bit                         hold_request = 1'b0;
  translation_board           board = new();

  tlb_page_table_translator #(
    .OFFSET_WIDTH (OFF_W),
    .PAGE_WIDTH   (PAGE_W),
    .FRAME_COUNT  (FRAME_SLOTS),
    .TLB_ENTRIES  (TLB_SLOTS)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .logical_address_i  (logical_address_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .physical_address_o (physical_address_o),
    .tlb_hit_o          (tlb_hit_o),
    .fault_taken_o      (fault_taken_o),
    .fault_frame_o      (fault_frame_o),
    .evicted_valid_o    (evicted_valid_o),
    .evicted_page_o     (evicted_page_o),
    .access_count_o     (access_count_o),
    .tlb_miss_count_o   (tlb_miss_count_o),
    .fault_count_o      (fault_count_o)
  );

  // Free-running clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Bound the run
  initial begin
    #(TIMEOUT_NS);
    $display("tb_top NOT OK");
    $finish;
  end

  // Check every result transaction at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_translation('{physical_address_o, tlb_hit_o, fault_taken_o,
                                fault_frame_o, evicted_valid_o, evicted_page_o,
                                access_count_o, tlb_miss_count_o, fault_count_o});
    end
  end

  // --------------------------------------------------------------------------
  // Result side stall pattern
  // --------------------------------------------------------------------------
  initial begin : stall_pattern
    int mode;
    int left;
    int step;
    int period;
    mode   = 0;
    left   = 0;
    step   = 0;
    period = 2;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        // hold off long enough for the block to back up into its input
        hold_request = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        if (left == 0) begin
          mode   = $urandom_range(3);
          left   = $urandom_range(256, 32);
          period = $urandom_range(5, 2);
        end
        left--;
        step++;
        case (mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(3) == 0);
          2:       out_stall_i <= ($urandom_range(3) != 0);
          default: out_stall_i <= (step % period == 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Address side
  // --------------------------------------------------------------------------
  // Offer one address from a falling edge and hold it until accepted
  task automatic send_addr(input logic [15:0] la);
    in_valid_i        <= 1'b1;
    logical_address_i <= la;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_address(la);
    @(negedge clk_i);
  endtask

  // Stop offering and wait for every outstanding result
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (board.pending() != 0) @(negedge clk_i);
  endtask

  initial begin : stimulus
    logic [15:0] directed_addr[20];
    logic [7:0]  hot_pages[8];
    logic [7:0]  scan_base;
    logic [15:0] la;
    bit          scan;
    int          sent;
    int          burst_len;
    int          gap;

    directed_addr = '{16'h0000, 16'h00FF, 16'h0080, 16'hFFFF, 16'hFF00,
                      16'h0001, 16'h8000, 16'h7FFF, 16'h8055, 16'h7FAA,
                      16'h0000, 16'hFFFF, 16'h8000, 16'h7F00, 16'h0101,
                      16'h0202, 16'h0101, 16'hFE7F, 16'h0202, 16'h01FE};
    foreach (hot_pages[i]) hot_pages[i] = 8'($urandom);
    sent = 0;

    // Hold reset, then release it at a falling edge
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: address extremes, hits after faults, misses without faults
    foreach (directed_addr[i]) send_addr(directed_addr[i]);
    wait_drained();

    // Random bursts with gaps
    while (sent < RANDOM_ITEMS) begin
      burst_len = $urandom_range(24, 1);
      scan      = ($urandom_range(9) == 0);
      scan_base = 8'($urandom);
      for (int b = 0; b < burst_len && sent < RANDOM_ITEMS; b++) begin
        la = 16'($urandom);
        if ($urandom_range(39) == 0) hot_pages[$urandom_range(7)] = 8'($urandom);
        if (scan) begin
          la[15:8] = scan_base + b[7:0];
        end else if ($urandom_range(99) < 60) begin
          la[15:8] = hot_pages[$urandom_range(7)];
        end
        if (sent == HOLD_AT) hold_request = 1'b1;
        if (sent == PAUSE_AT) wait_drained();
        send_addr(la);
        sent++;
      end
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 1);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end

    // Drain, let the pipeline settle, report
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/tpt_pkg.sv
src/tpt_ram.sv
src/tpt_tlb.sv
src/tlb_page_table_translator.sv
tb/sv/tb_top.sv
